// ===== design/psp_pkg.sv =====
// ----------------------------------------------------------------------------
// psp_pkg
// shared types and constants of the planar sprite palette decoder
// ----------------------------------------------------------------------------
`default_nettype none

package psp_pkg;

	localparam int XY_W      = 12;
	localparam int CNT_W     = 24;
	localparam int NEED_W    = 20;
	localparam int START_W   = 9;
	localparam int RGB_W     = 18;
	localparam int FQ_DEPTH  = 4;
	localparam int FQ_AW     = 2;
	localparam int PADDR_W   = 4;

	localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0]   HDR_BYTES   = CNT_W'(2);
	localparam logic [START_W-1:0] START_RESET = START_W'(4);

	localparam logic [1:0] FUNC_BYTE  = 2'd0;
	localparam logic [1:0] FUNC_PAL   = 2'd1;
	localparam logic [1:0] FUNC_REMAP = 2'd2;

	localparam logic KIND_PIX  = 1'b0;
	localparam logic KIND_STAT = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	localparam logic [1:0] REG_REMAP_EN = 2'd0;
	localparam logic [1:0] REG_CHUNKY   = 2'd1;
	localparam logic [1:0] REG_WIDTH    = 2'd2;
	localparam logic [1:0] REG_HEIGHT   = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] byte_value;
		logic       last_byte;
		logic [7:0] table_index;
		logic [5:0] red_six;
		logic [5:0] green_six;
		logic [5:0] blue_six;
		logic [7:0] remap_target;
	} item_t;

	typedef struct packed {
		logic            kind;
		logic [XY_W-1:0] pixel_x;
		logic [XY_W-1:0] pixel_y;
		logic [7:0]      red;
		logic [7:0]      green;
		logic [7:0]      blue;
		logic [7:0]      alpha;
		logic [1:0]      status;
		logic            last;
	} result_t;

	typedef struct packed {
		logic             remap_enable;
		logic             chunky_mode;
		logic [11:0]      chunky_width;
		logic [11:0]      chunky_height;
		logic [CNT_W-1:0] chunky_need;
	} cfg_t;

	typedef struct packed {
		logic            has_pix;
		logic            has_stat;
		logic [1:0]      status;
		logic [XY_W-1:0] x;
		logic [XY_W-1:0] y;
		logic [7:0]      idx;
	} stage_t;

	typedef struct packed {
		logic            has_pix;
		logic            has_stat;
		logic [1:0]      status;
		logic [XY_W-1:0] x;
		logic [XY_W-1:0] y;
		logic [RGB_W-1:0] rgb;
		logic            opaque;
	} entry_t;

endpackage

`default_nettype wire

// ===== design/psp_regs.sv =====
// ----------------------------------------------------------------------------
// psp_regs
// configuration registers behind the apb-style port, with the chunky pixel count
// ----------------------------------------------------------------------------
`default_nettype none

module psp_regs
	import psp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output cfg_t                    cfg
);

	logic        remap_enable_q;
	logic        chunky_mode_q;
	logic [11:0] chunky_width_q;
	logic [11:0] chunky_height_q;
	logic        wr;
	logic [1:0]  sel;

	assign wr  = psel && penable && pwrite;
	assign sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remap_enable_q  <= 1'b0;
			chunky_mode_q   <= 1'b0;
			chunky_width_q  <= '0;
			chunky_height_q <= '0;
		end else begin
			if (wr) begin
				unique case (sel)
					REG_REMAP_EN: remap_enable_q  <= pwdata[0];
					REG_CHUNKY:   chunky_mode_q   <= pwdata[0];
					REG_WIDTH:    chunky_width_q  <= pwdata[11:0];
					REG_HEIGHT:   chunky_height_q <= pwdata[11:0];
					default:      remap_enable_q  <= remap_enable_q;
				endcase
			end
		end
	end

	always_comb begin
		unique case (sel)
			REG_REMAP_EN: prdata = {31'd0, remap_enable_q};
			REG_CHUNKY:   prdata = {31'd0, chunky_mode_q};
			REG_WIDTH:    prdata = {20'd0, chunky_width_q};
			REG_HEIGHT:   prdata = {20'd0, chunky_height_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.remap_enable  = remap_enable_q;
	assign cfg.chunky_mode   = chunky_mode_q;
	assign cfg.chunky_width  = chunky_width_q;
	assign cfg.chunky_height = chunky_height_q;
	assign cfg.chunky_need   = CNT_W'(chunky_width_q) * CNT_W'(chunky_height_q);

endmodule

`default_nettype wire

// ===== design/psp_ctrl.sv =====
// ----------------------------------------------------------------------------
// psp_ctrl
// record parser: header, byte and pixel counters, pixel position and status
// ----------------------------------------------------------------------------
`default_nettype none

module psp_ctrl
	import psp_pkg::*;
#(
	parameter int DIM_BITS = 12
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  take,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output stage_t     pix_s1
);

	localparam int CMP_W = DIM_BITS + 5;

	logic [7:0]          height_q;
	logic [7:0]          weighths_q;
	logic [CNT_W-1:0]    bytes_q;
	logic [1:0]          plane_q;
	logic [DIM_BITS-1:0] row_q;
	logic [DIM_BITS-1:0] col_q;
	logic [CNT_W-1:0]    done_q;
	logic [NEED_W-1:0]   need_q;
	logic [START_W-1:0]  start_q;

	logic                rec;
	logic [CNT_W-1:0]    cnt_n;
	logic [7:0]          h_n;
	logic [7:0]          w_n;
	logic                emit;
	logic [1:0]          status;
	logic [XY_W-1:0]     x;
	logic [1:0]          plane_n;
	logic [DIM_BITS-1:0] row_n;
	logic [DIM_BITS-1:0] col_n;
	logic [CMP_W-1:0]    col_inc;
	logic [CMP_W-1:0]    row_inc;
	logic [15:0]         area;
	logic [START_W-1:0]  start_n;

	assign rec     = take && (item.func == FUNC_BYTE);
	assign cnt_n   = (bytes_q == CNT_MAX) ? bytes_q : bytes_q + CNT_W'(1);
	assign col_inc = CMP_W'(col_q) + CMP_W'(1);
	assign row_inc = CMP_W'(row_q) + CMP_W'(1);
	assign h_n     = (!cfg.chunky_mode && bytes_q == '0) ? item.byte_value : height_q;
	assign w_n     = (!cfg.chunky_mode && bytes_q == CNT_W'(1)) ? item.byte_value : weighths_q;
	assign area    = w_n * h_n;
	assign start_n = (START_W'(h_n) + START_W'(5)) & ~START_W'(3);

	always_comb begin
		plane_n = plane_q;
		row_n   = row_q;
		col_n   = col_q;
		if (cfg.chunky_mode) begin
			emit = done_q < cfg.chunky_need;
			x    = XY_W'(col_q);
			if (cfg.chunky_width == '0 || cfg.chunky_height == '0) begin
				status = ST_ZERO;
			end else if (cnt_n < cfg.chunky_need) begin
				status = ST_TRUNC;
			end else begin
				status = ST_OK;
			end
			if (col_inc >= CMP_W'(cfg.chunky_width)) begin
				col_n = '0;
				row_n = row_q + DIM_BITS'(1);
			end else begin
				col_n = col_q + DIM_BITS'(1);
			end
		end else begin
			emit = (bytes_q >= HDR_BYTES) && (bytes_q >= CNT_W'(start_q))
				&& (done_q < CNT_W'(need_q));
			x    = XY_W'({col_q, plane_q});
			if (bytes_q < HDR_BYTES) begin
				status = ST_SHORT;
			end else if (h_n == '0 || w_n == '0) begin
				status = ST_ZERO;
			end else if (CNT_W'(start_q) + CNT_W'(need_q) > cnt_n) begin
				status = ST_TRUNC;
			end else begin
				status = ST_OK;
			end
			if (col_inc >= CMP_W'({weighths_q, 1'b0})) begin
				col_n = '0;
				if (row_inc >= CMP_W'(height_q)) begin
					row_n   = '0;
					plane_n = plane_q + 2'd1;
				end else begin
					row_n = row_q + DIM_BITS'(1);
				end
			end else begin
				col_n = col_q + DIM_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q   <= '0;
			weighths_q <= '0;
			bytes_q    <= '0;
			plane_q    <= '0;
			row_q      <= '0;
			col_q      <= '0;
			done_q     <= '0;
			need_q     <= '0;
			start_q    <= START_RESET;
		end else if (rec) begin
			if (item.last_byte) begin
				height_q   <= '0;
				weighths_q <= '0;
				bytes_q    <= '0;
				plane_q    <= '0;
				row_q      <= '0;
				col_q      <= '0;
				done_q     <= '0;
				need_q     <= '0;
				start_q    <= START_RESET;
			end else begin
				height_q   <= h_n;
				weighths_q <= w_n;
				bytes_q    <= cnt_n;
				need_q     <= NEED_W'({area, 3'b000});
				start_q    <= start_n;
				if (emit) begin
					plane_q <= plane_n;
					row_q   <= row_n;
					col_q   <= col_n;
					done_q  <= done_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= '0;
		end else begin
			pix_s1.has_pix  <= rec && emit;
			pix_s1.has_stat <= rec && item.last_byte;
			pix_s1.status   <= status;
			pix_s1.x        <= x;
			pix_s1.y        <= XY_W'(row_q);
			pix_s1.idx      <= item.byte_value;
		end
	end

endmodule

`default_nettype wire

// ===== design/psp_lookup.sv =====
// ----------------------------------------------------------------------------
// psp_lookup
// remap and palette memories, colour lookup pipeline with registered memory reads
// ----------------------------------------------------------------------------
`default_nettype none

module psp_lookup
	import psp_pkg::*;
#(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   take,
	input  wire item_t  item,
	input  wire cfg_t   cfg,
	input  wire stage_t pix_s1,
	output logic        busy_s2,
	output logic        push,
	output entry_t      entry
);

	localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [7:0]       remap_ram [256];
	logic [RGB_W-1:0] pal_ram [PALETTE_DEPTH];
	logic [7:0]       remap_rd_q;
	logic [RGB_W-1:0] pal_rd_q;
	logic             remap_we;
	logic             pal_we;
	logic [7:0]       pal_addr;
	stage_t           pix_s2;
	logic             oor_s2;

	assign remap_we = take && (item.func == FUNC_REMAP);
	assign pal_we   = take && (item.func == FUNC_PAL)
		&& (9'(item.table_index) < 9'(PALETTE_DEPTH));
	assign pal_addr = (cfg.remap_enable && pix_s1.idx != '0) ? remap_rd_q : pix_s1.idx;

	always_ff @(posedge clk) begin
		if (remap_we) begin
			remap_ram[item.table_index] <= item.remap_target;
		end
		remap_rd_q <= remap_ram[item.byte_value];
	end

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_ram[item.table_index[PAL_AW-1:0]] <= {item.red_six, item.green_six,
				item.blue_six};
		end
		pal_rd_q <= pal_ram[pal_addr[PAL_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s2 <= '0;
		end else begin
			pix_s2 <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		oor_s2 <= 9'(pal_addr) >= 9'(PALETTE_DEPTH);
	end

	assign busy_s2 = pix_s2.has_pix || pix_s2.has_stat;
	assign push    = busy_s2;

	always_comb begin
		entry.has_pix  = pix_s2.has_pix;
		entry.has_stat = pix_s2.has_stat;
		entry.status   = pix_s2.status;
		entry.x        = pix_s2.x;
		entry.y        = pix_s2.y;
		entry.opaque   = pix_s2.idx != '0;
		entry.rgb      = (pix_s2.idx == '0 || oor_s2) ? '0 : pal_rd_q;
	end

endmodule

`default_nettype wire

// ===== design/psp_outq.sv =====
// ----------------------------------------------------------------------------
// psp_outq
// result queue; splits an entry into its pixel and status results
// ----------------------------------------------------------------------------
`default_nettype none

module psp_outq
	import psp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire entry_t       entry,
	output logic [FQ_AW:0]    count,
	output logic              result_valid,
	input  wire logic         result_stall,
	output result_t           result
);

	entry_t           fifo_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_ptr_q;
	logic [FQ_AW-1:0] rd_ptr_q;
	logic [FQ_AW:0]   count_q;
	logic             phase_q;
	entry_t           head;
	logic             show_pix;
	logic             taken;
	logic             pop;

	assign head         = fifo_q[rd_ptr_q];
	assign result_valid = count_q != '0;
	assign show_pix     = head.has_pix && !phase_q;
	assign taken        = result_valid && !result_stall;
	assign pop          = taken && !(show_pix && head.has_stat);
	assign count        = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FQ_AW'(1);
				phase_q  <= 1'b0;
			end else if (taken) begin
				phase_q <= 1'b1;
			end
			count_q <= count_q + (FQ_AW+1)'(push) - (FQ_AW+1)'(pop);
		end
	end

	always_comb begin
		result = '0;
		if (show_pix) begin
			result.kind    = KIND_PIX;
			result.pixel_x = head.x;
			result.pixel_y = head.y;
			result.red     = {head.rgb[17:12], 2'b00};
			result.green   = {head.rgb[11:6], 2'b00};
			result.blue    = {head.rgb[5:0], 2'b00};
			result.alpha   = head.opaque ? 8'hFF : 8'h00;
		end else begin
			result.kind    = KIND_STAT;
			result.status  = head.status;
			result.last    = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== design/planar_sprite_palette_decoder.sv =====
// ----------------------------------------------------------------------------
// planar_sprite_palette_decoder
// decodes a streamed planar or chunky sprite record through remap and palette
// ----------------------------------------------------------------------------
// usage:
//  item channel (item_valid, item_stall, item) carries record bytes and
//  palette or remap entry writes; result channel (result_valid, result_stall,
//  result) carries pixel results and the end-of-record status result.
//  configuration registers sit behind the apb-style port at 0x0, 0x4, 0x8, 0xc.
//  a record byte passes through the parser and remap memory read, then the
//  palette memory read, then the result queue, before its results are
//  offered. one item is taken every cycle while item_stall is low; a
//  byte that ends a record and also carries a pixel gives two results, the
//  status after the pixel. the rate is set by the palette memory read port,
//  one lookup per cycle.
//  a four-entry result queue decouples the sides; item_stall rises when the
//  queue plus the two lookup stages could not hold another item's results,
//  so a stalled receiver stops intake once four result-carrying items are
//  pending.
//  reset clears registers, counters and the queue; palette and remap contents
//  stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_sprite_palette_decoder
	import psp_pkg::*;
#(
	parameter int PALETTE_DEPTH = 256,
	parameter int DIM_BITS      = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire item_t              item,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output result_t                 result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	localparam int CW = FQ_AW + 2;

	cfg_t           cfg;
	stage_t         pix_s1;
	entry_t         entry;
	logic           push;
	logic           busy_s2;
	logic [FQ_AW:0] count;
	logic           take;
	logic [CW-1:0]  pending;

	assign pready     = 1'b1;
	assign pending    = CW'(count) + CW'(pix_s1.has_pix || pix_s1.has_stat) + CW'(busy_s2);
	assign item_stall = pending >= CW'(FQ_DEPTH);
	assign take       = item_valid && !item_stall;

	psp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	psp_ctrl #(
		.DIM_BITS (DIM_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.cfg    (cfg),
		.pix_s1 (pix_s1)
	);

	psp_lookup #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_lookup (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.item    (item),
		.cfg     (cfg),
		.pix_s1  (pix_s1),
		.busy_s2 (busy_s2),
		.push    (push),
		.entry   (entry)
	);

	psp_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.entry        (entry),
		.count        (count),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== verif/tb_planar_sprite_palette_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_planar_sprite_palette_decoder
// self-checking bench: fills the palette and remap tables, then streams
// planar and chunky sprite records under several register settings, with
// random gaps on both sides and a long receiver hold-off; every result
// transaction is compared field by field with an in-bench decoder model
// ----------------------------------------------------------------------------

module tb_planar_sprite_palette_decoder;
	import psp_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int ITEMS = 1150;
	localparam int LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int N_PHASES = 6;

	class pixel_board;
		logic [17:0] palette [256];
		logic [7:0] remap [256];
		logic remap_en, chunky;
		logic [11:0] width_px, height_px;
		int unsigned height, w8, byte_cnt, plane, row, col, done;
		result_t due_results[$];
		int unsigned mismatches;

		function new();
			remap_en = 1'b0;
			chunky = 1'b0;
			width_px = '0;
			height_px = '0;
			mismatches = 0;
			clear_record();
		endfunction

		function void clear_record();
			height = 0;
			w8 = 0;
			byte_cnt = 0;
			plane = 0;
			row = 0;
			col = 0;
			done = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_REMAP_EN: remap_en = val[0];
				REG_CHUNKY: chunky = val[0];
				REG_WIDTH: width_px = val[11:0];
				REG_HEIGHT: height_px = val[11:0];
				default: ;
			endcase
		endfunction

		function result_t pixel_of(int unsigned x, int unsigned y, logic [7:0] v);
			result_t r;
			logic [7:0] pv;
			logic [17:0] rgb;
			r = '0;
			r.kind = KIND_PIX;
			r.pixel_x = x[11:0];
			r.pixel_y = y[11:0];
			if (v != 8'd0) begin
				pv = remap_en ? remap[v] : v;
				rgb = palette[pv];
				r.red = {rgb[17:12], 2'b00};
				r.green = {rgb[11:6], 2'b00};
				r.blue = {rgb[5:0], 2'b00};
				r.alpha = 8'hff;
			end
			return r;
		endfunction

		function void take_item(item_t it);
			int unsigned pos, cnt, need, start, cols;
			logic [1:0] st;
			result_t s;
			case (it.func)
				FUNC_PAL: palette[it.table_index] = {it.red_six, it.green_six, it.blue_six};
				FUNC_REMAP: remap[it.table_index] = it.remap_target;
				FUNC_BYTE: begin
					pos = byte_cnt;
					if (byte_cnt < 32'hffffff)
						byte_cnt++;
					cnt = byte_cnt;
					if (chunky) begin
						need = 32'(width_px) * 32'(height_px);
						if (done < need) begin
							due_results = {due_results, pixel_of(col, row, it.byte_value)};
							done++;
							if (col + 1 >= 32'(width_px)) begin
								col = 0;
								row = (row + 1) & 32'hfff;
							end else begin
								col = (col + 1) & 32'hfff;
							end
						end
						if (width_px == 0 || height_px == 0)
							st = ST_ZERO;
						else if (cnt < need)
							st = ST_TRUNC;
						else
							st = ST_OK;
					end else begin
						if (pos == 0)
							height = it.byte_value;
						else if (pos == 1)
							w8 = it.byte_value;
						cols = w8 * 2;
						need = w8 * 8 * height;
						start = (height + 5) & ~32'd3;
						if (pos >= 2 && pos >= start && done < need) begin
							due_results = {due_results,
								pixel_of(plane + 4 * col, row, it.byte_value)};
							done++;
							if (col + 1 >= cols) begin
								col = 0;
								if (row + 1 >= height) begin
									row = 0;
									plane = (plane + 1) & 32'd3;
								end else begin
									row = (row + 1) & 32'hfff;
								end
							end else begin
								col = (col + 1) & 32'hfff;
							end
						end
						if (cnt <= 2)
							st = ST_SHORT;
						else if (height == 0 || w8 == 0)
							st = ST_ZERO;
						else if (start + need > cnt)
							st = ST_TRUNC;
						else
							st = ST_OK;
					end
					if (it.last_byte) begin
						s = '0;
						s.kind = KIND_STAT;
						s.status = st;
						s.last = 1'b1;
						due_results = {due_results, s};
						clear_record();
					end
				end
				default: ;
			endcase
		endfunction

		function string show(result_t r);
			return $sformatf("kind %0d x %0d y %0d rgba %02h %02h %02h %02h status %0d last %0d",
				r.kind, r.pixel_x, r.pixel_y, r.red, r.green, r.blue, r.alpha,
				r.status, r.last);
		endfunction

		function void check_result(result_t got);
			result_t want;
			bit bad;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %s", show(got));
			end else begin
				want = due_results.pop_front();
				bad = (got.kind !== want.kind) || (got.pixel_x !== want.pixel_x) ||
					(got.pixel_y !== want.pixel_y) || (got.red !== want.red) ||
					(got.green !== want.green) || (got.blue !== want.blue) ||
					(got.alpha !== want.alpha) || (got.status !== want.status) ||
					(got.last !== want.last);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %s, got %s", show(want), show(got));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pixel_board board;
	int send_idle_pct = 7;
	int stall_pct = 53;
	logic hold_req = 1'b0;
	int hold_left = 0;
	int cycles = 0;
	int counted = 0;
	int base = 0;
	bit noise_on = 1'b0;

	int unsigned ph_remap [N_PHASES] = '{0, 1, 0, 1, 1, 0};
	int unsigned ph_chunky [N_PHASES] = '{0, 0, 1, 1, 0, 1};
	int unsigned ph_w [N_PHASES] = '{0, 4095, 5, 1, 12, 16};
	int unsigned ph_h [N_PHASES] = '{0, 4095, 3, 6, 1, 2};

	planar_sprite_palette_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: check, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_result(result);
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
		end
		result_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
	end

	task automatic send_item(input item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		board.take_item(it);
		if (it.func != FUNC_NONE)
			counted++;
	endtask

	function automatic item_t byte_item(logic [7:0] v, logic lastb);
		item_t it;
		it = item_t'({$urandom, $urandom});
		it.func = FUNC_BYTE;
		it.byte_value = v;
		it.last_byte = lastb;
		return it;
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it = item_t'({$urandom, $urandom});
		case ($urandom_range(0, 2))
			0: it.func = FUNC_PAL;
			1: it.func = FUNC_REMAP;
			default: it.func = FUNC_NONE;
		endcase
		return it;
	endfunction

	function automatic logic [7:0] rand_pixel();
		return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
	endfunction

	task automatic send_list(input logic [7:0] bytes[$], input bit close);
		for (int i = 0; i < bytes.size(); i++) begin
			if (noise_on && $urandom_range(0, 24) == 0)
				send_item(noise_item());
			send_item(byte_item(bytes[i], close && (i == bytes.size() - 1)));
		end
	endtask

	task automatic send_planar(input int unsigned h, input int unsigned w8,
			input int unsigned len);
		logic [7:0] bytes[$];
		int unsigned start;
		start = (h + 5) & ~32'd3;
		for (int unsigned i = 0; i < len; i++) begin
			if (i == 0)
				bytes = {bytes, h[7:0]};
			else if (i == 1)
				bytes = {bytes, w8[7:0]};
			else if (i < start)
				bytes = {bytes, 8'($urandom_range(0, 255))};
			else
				bytes = {bytes, rand_pixel()};
		end
		send_list(bytes, 1'b1);
	endtask

	task automatic send_chunky(input int unsigned len);
		logic [7:0] bytes[$];
		for (int unsigned i = 0; i < len; i++)
			bytes = {bytes, rand_pixel()};
		send_list(bytes, 1'b1);
	endtask

	task automatic random_planar();
		int unsigned h, w8, full, len;
		h = $urandom_range(1, 5);
		if ($urandom_range(0, 15) == 0)
			h = $urandom_range(6, 20);
		w8 = $urandom_range(1, 2);
		full = ((h + 5) & ~32'd3) + 8 * w8 * h;
		case ($urandom_range(0, 9))
			0: begin
				h = $urandom_range(0, 255);
				w8 = $urandom_range(0, 255);
				len = $urandom_range(1, 2);
			end
			1: begin
				if ($urandom_range(0, 1) == 0)
					h = 0;
				else
					w8 = 0;
				len = $urandom_range(3, 8);
			end
			2: len = $urandom_range(3, full - 1);
			3: len = full + $urandom_range(1, 4);
			default: len = full;
		endcase
		send_planar(h, w8, len);
	endtask

	task automatic random_chunky(input int unsigned need);
		int unsigned len;
		len = need;
		case ($urandom_range(0, 7))
			0: if (need > 1) len = $urandom_range(1, need - 1);
			1: len = need + $urandom_range(1, 3);
			default: ;
		endcase
		send_chunky(len);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic write_config(input int unsigned remap_en, input int unsigned chunky,
			input int unsigned w, input int unsigned h);
		reg_write(REG_REMAP_EN, remap_en);
		reg_write(REG_CHUNKY, chunky);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (board.due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_tables();
		item_t it;
		for (int i = 0; i < 256; i++) begin
			it = item_t'({$urandom, $urandom});
			it.func = FUNC_PAL;
			it.table_index = 8'(i);
			if (i == 255)
				{it.red_six, it.green_six, it.blue_six} = '1;
			else if (i == 1)
				{it.red_six, it.green_six, it.blue_six} = '0;
			send_item(it);
		end
		for (int i = 0; i < 256; i++) begin
			it = item_t'({$urandom, $urandom});
			it.func = FUNC_REMAP;
			it.table_index = 8'(i);
			if (i == 0)
				it.remap_target = 8'd0;
			else if (i == 255)
				it.remap_target = 8'hff;
			send_item(it);
		end
	endtask

	task automatic set_pressure();
		if (counted - base < ITEMS / 3) begin
			send_idle_pct = 7;
			stall_pct = 53;
		end else if (counted - base < 2 * ITEMS / 3) begin
			send_idle_pct = 53;
			stall_pct = 7;
		end else begin
			send_idle_pct = 0;
			stall_pct = 0;
		end
	endtask

	initial begin
		item_t odd;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_config(0, 0, 0, 0);
		load_tables();

		// short records, zero size, full record with index 0 and 255, truncation
		send_planar(7, 0, 1);
		send_planar(0, 0, 2);
		send_planar(0, 3, 3);
		send_list('{8'd1, 8'd1, 8'd0, 8'hff, 8'd0, 8'hff, 8'd1, 8'd128,
			8'd2, 8'd3, 8'd4, 8'd5}, 1'b1);
		send_planar(255, 255, 3);
		odd = noise_item();
		odd.func = FUNC_NONE;
		odd.last_byte = 1'b1;
		send_item(odd);

		// mode and remap change in the middle of a record
		send_list('{8'd1, 8'd1, 8'd9, 8'd9, 8'd5}, 1'b0);
		wait_idle();
		write_config(1, 1, 3, 2);
		send_chunky(1);
		wait_idle();
		write_config(0, 1, 0, 9);
		send_chunky(1);
		wait_idle();
		write_config(1, 1, 4095, 4095);
		send_chunky(3);

		base = counted;
		noise_on = 1'b1;
		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			write_config(ph_remap[p], ph_chunky[p], ph_w[p], ph_h[p]);
			if (p == 1) begin
				hold_req <= 1'b1;
				send_planar(4, 2, 72);
			end
			while (counted - base < (p + 1) * ITEMS / N_PHASES) begin
				set_pressure();
				if (ph_chunky[p] != 0)
					random_chunky(ph_w[p] * ph_h[p]);
				else
					random_planar();
			end
		end

		wait_idle();
		if (board.mismatches == 0 && board.due_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
